FILE: hw/rtl/u8d_pkg.sv
`default_nettype none

package u8d_pkg;

	localparam logic [20:0] REPL_CP    = 21'h00FFFD;
	localparam logic [20:0] MAX_CP     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MIN_CP_2B  = 21'h000080;
	localparam logic [20:0] MIN_CP_3B  = 21'h000800;
	localparam logic [20:0] MIN_CP_4B  = 21'h010000;

	localparam logic [1:0] CLASS_NONE = 2'd0;
	localparam logic [1:0] CLASS_2B   = 2'd1;
	localparam logic [1:0] CLASS_3B   = 2'd2;
	localparam logic [1:0] CLASS_4B   = 2'd3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       text_end;
	} u8d_in_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        is_replacement;
		logic        run_last;
		logic        text_done;
	} u8d_out_t;

	// one cmd per byte with output: replacements before, main result, replacements after
	typedef struct packed {
		logic [20:0] main_cp;
		logic        main_repl;
		logic        main_valid;
		logic [1:0]  n_pre;
		logic [2:0]  cnt;
		logic        last;
	} u8d_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/u8d_front.sv
`default_nettype none

module u8d_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire u8d_pkg::u8d_in_t  data,
	output u8d_pkg::u8d_cmd_t      cmd,
	output logic                   cmd_valid
);
	import u8d_pkg::*;

	logic [20:0] pv_q, pv_d;
	logic [1:0]  exp_q, exp_d;
	logic [1:0]  seen_q, seen_d;
	logic [1:0]  cls_q, cls_d;

	logic [7:0]  b;
	logic        cont;
	logic [20:0] shifted;
	logic [20:0] min_cp;
	logic        bad;
	logic        main_v;
	logic [20:0] main_cp;
	logic        main_r;
	logic [1:0]  n_pre;
	logic [1:0]  n_post;
	logic [2:0]  cnt;

	assign b       = data.data_byte;
	assign cont    = (b[7:6] == 2'b10);
	assign shifted = {pv_q[14:0], b[5:0]};

	always_comb begin
		case (cls_q)
			CLASS_2B: min_cp = MIN_CP_2B;
			CLASS_3B: min_cp = MIN_CP_3B;
			default:  min_cp = MIN_CP_4B;
		endcase
	end

	assign bad = (shifted < min_cp) || (shifted > MAX_CP) ||
	             ((shifted >= SURR_LO) && (shifted <= SURR_HI));

	always_comb begin
		pv_d    = pv_q;
		exp_d   = exp_q;
		seen_d  = seen_q;
		cls_d   = cls_q;
		main_v  = 1'b0;
		main_cp = REPL_CP;
		main_r  = 1'b1;
		n_pre   = 2'd0;
		n_post  = 2'd0;
		if (exp_q != 2'd0 && cont) begin
			pv_d   = shifted;
			seen_d = seen_q + 2'd1;
			if (seen_d >= exp_q) begin
				main_v  = 1'b1;
				main_cp = bad ? REPL_CP : shifted;
				main_r  = bad;
				pv_d    = '0;
				exp_d   = 2'd0;
				seen_d  = 2'd0;
				cls_d   = CLASS_NONE;
			end
		end else begin
			if (exp_q != 2'd0) begin
				// interrupted sequence
				n_pre  = seen_q + 2'd1;
				pv_d   = '0;
				exp_d  = 2'd0;
				seen_d = 2'd0;
				cls_d  = CLASS_NONE;
			end
			if (b < 8'h80) begin
				main_v  = 1'b1;
				main_cp = {13'd0, b};
				main_r  = 1'b0;
			end else if (b inside {[8'hC2:8'hDF]}) begin
				pv_d   = {16'd0, b[4:0]};
				exp_d  = 2'd1;
				seen_d = 2'd0;
				cls_d  = CLASS_2B;
			end else if (b inside {[8'hE0:8'hEF]}) begin
				pv_d   = {17'd0, b[3:0]};
				exp_d  = 2'd2;
				seen_d = 2'd0;
				cls_d  = CLASS_3B;
			end else if (b inside {[8'hF0:8'hF4]}) begin
				pv_d   = {18'd0, b[2:0]};
				exp_d  = 2'd3;
				seen_d = 2'd0;
				cls_d  = CLASS_4B;
			end else begin
				main_v  = 1'b1;
				main_cp = REPL_CP;
				main_r  = 1'b1;
			end
		end
		if (data.text_end && exp_d != 2'd0) begin
			// text ends inside a sequence
			n_post = seen_d + 2'd1;
			pv_d   = '0;
			exp_d  = 2'd0;
			seen_d = 2'd0;
			cls_d  = CLASS_NONE;
		end
	end

	assign cnt = {1'b0, n_pre} + {2'b00, main_v} + {1'b0, n_post};

	assign cmd.main_cp    = main_cp;
	assign cmd.main_repl  = main_r;
	assign cmd.main_valid = main_v;
	assign cmd.n_pre      = n_pre;
	assign cmd.cnt        = cnt;
	assign cmd.last       = data.text_end;
	assign cmd_valid      = accept && (cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			exp_q  <= 2'd0;
			seen_q <= 2'd0;
			cls_q  <= CLASS_NONE;
		end else if (accept) begin
			pv_q   <= pv_d;
			exp_q  <= exp_d;
			seen_q <= seen_d;
			cls_q  <= cls_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/u8d_fifo.sv
`default_nettype none

module u8d_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire u8d_pkg::u8d_cmd_t  wr_cmd,
	input  wire logic               rd_en,
	output u8d_pkg::u8d_cmd_t       rd_cmd,
	output logic                    empty,
	output logic                    full
);
	import u8d_pkg::*;

	u8d_cmd_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign empty  = (count_q == FIFO_CW'(0));
	assign full   = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/u8d_back.sv
`default_nettype none

module u8d_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u8d_pkg::u8d_cmd_t  head,
	input  wire logic               head_empty,
	output logic                    deq,
	output u8d_pkg::u8d_out_t       result,
	output logic                    empty,
	input  wire logic               pop
);
	import u8d_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	u8d_out_t   out_q;
	logic       load;
	logic       at_last;
	logic       is_main;
	u8d_out_t   item;

	assign load    = !head_empty && (!out_valid_q || pop);
	assign at_last = ({1'b0, idx_q} == (head.cnt - 3'd1));
	assign is_main = head.main_valid && (idx_q == head.n_pre);
	assign deq     = load && at_last;

	always_comb begin
		item.code_point     = is_main ? head.main_cp : REPL_CP;
		item.is_replacement = is_main ? head.main_repl : 1'b1;
		item.run_last       = at_last;
		item.text_done      = at_last && head.last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

`ifndef SYNTH
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!head_empty |-> ({1'b0, idx_q} < head.cnt))
		else $error("item index past command count");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		head_empty |-> (idx_q == 2'd0))
		else $error("item index nonzero with no command");
	a_repl_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_replacement) |-> (out_q.code_point == REPL_CP))
		else $error("replacement item without U+FFFD");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.text_done) |-> out_q.run_last)
		else $error("text_done on an item that is not the last of its byte");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/utf8_decoder_with_replacement.sv
// UTF-8 decoder with U+FFFD replacement.
// Input channel: data carries one byte and a text_end flag; a byte is taken
// at a clock edge with push high and full low.
// Result channel: result holds the oldest code point while empty is low; it
// is taken at a clock edge with pop high and empty low. run_last marks the
// last result caused by one byte, text_done the final result of a text.
// A byte that completes a character, or is ASCII or an invalid lead, gives one
// result; a continuation byte inside a sequence gives none; an interrupted or
// cut-off sequence gives up to four replacements.
// Each result passes through the command queue and then the output register.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver keeps up; a byte with several results holds the result stage
// until each has left the single output register. A four-entry command queue
// between the byte classifier and the result stage absorbs these runs.
// When the receiver stalls, the queue fills and full rises; no item is lost.
// Reset clears any pending sequence and empties queue and output register.
`default_nettype none

module utf8_decoder_with_replacement (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire u8d_pkg::u8d_in_t  data,
	output logic                   empty,
	input  wire logic              pop,
	output u8d_pkg::u8d_out_t      result
);
	import u8d_pkg::*;

	u8d_cmd_t cmd;
	logic     cmd_valid;
	u8d_cmd_t head;
	logic     head_empty;
	logic     deq;
	logic     accept;

	assign accept = push && !full;

	u8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data      (data),
		.cmd       (cmd),
		.cmd_valid (cmd_valid)
	);

	u8d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_valid),
		.wr_cmd (cmd),
		.rd_en  (deq),
		.rd_cmd (head),
		.empty  (head_empty),
		.full   (full)
	);

	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.deq        (deq),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

`default_nettype wire
